/* hw/rtl/byte_fifo_with_peek_and_checksum_macros.svh */
// Assertion helpers for the RTL; only bfpc_back includes them.
`ifndef BYTE_FIFO_WITH_PEEK_AND_CHECKSUM_MACROS_SVH
`define BYTE_FIFO_WITH_PEEK_AND_CHECKSUM_MACROS_SVH

`ifndef NO_ASSERTIONS
`define BFPC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define BFPC_NEVER(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);
`else
`define BFPC_ASSERT(lbl, clk, rstn, prop, msg)
`define BFPC_NEVER(lbl, clk, rstn, expr, msg)
`endif

`endif

/* hw/rtl/bfpc_pkg.sv */
`default_nettype none

package bfpc_pkg;

  localparam int OPCODE_W = 3;
  localparam int BYTE_W   = 8;
  localparam int POS_W    = 6;
  localparam int LEN_W    = 7;
  localparam int STATUS_W = 2;
  localparam int SUM_W    = 16;
  localparam int FILL_W   = 7;

  typedef enum logic [OPCODE_W-1:0] {
    OP_PUSH     = 3'd0,
    OP_POP      = 3'd1,
    OP_PEEK     = 3'd2,
    OP_CLEAR    = 3'd3,
    OP_CHECKSUM = 3'd4,
    OP_NOP      = 3'd5
  } op_e;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;
  localparam logic [STATUS_W-1:0] ST_SHORT     = 2'd3;

  typedef struct packed {
    op_e               kind;
    logic [BYTE_W-1:0] data;
    logic [POS_W-1:0]  pos;
    logic [LEN_W-1:0]  len;
  } cmd_t;

endpackage

`default_nettype wire

/* hw/rtl/bfpc_front.sv */
`default_nettype none

module bfpc_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [bfpc_pkg::OPCODE_W-1:0] opcode_i,
  input  logic [bfpc_pkg::BYTE_W-1:0]   data_in_i,
  input  logic [bfpc_pkg::POS_W-1:0]    position_i,
  input  logic [bfpc_pkg::LEN_W-1:0]    length_i,
  output logic                         cmd_valid_o,
  output bfpc_pkg::cmd_t               cmd_o,
  input  logic                         cmd_pop_i
);
  import bfpc_pkg::*;

  // power-of-two depth, so the slot pointers wrap on their own
  localparam int QD  = 2;
  localparam int QAW = $clog2(QD);
  localparam int QCW = $clog2(QD + 1);

  cmd_t           slot_q [QD];
  logic [QAW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QAW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCW-1:0] cnt_q, cnt_d;
  logic           push;
  cmd_t           cmd_in;

  assign busy        = (cnt_q == QCW'(QD));
  assign push        = start && !busy;
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = slot_q[rd_ptr_q];

  // classify: opcodes outside the list become no-operations
  always_comb begin
    cmd_in.data = data_in_i;
    cmd_in.pos  = position_i;
    cmd_in.len  = length_i;
    case (opcode_i)
      OP_PUSH:     cmd_in.kind = OP_PUSH;
      OP_POP:      cmd_in.kind = OP_POP;
      OP_PEEK:     cmd_in.kind = OP_PEEK;
      OP_CLEAR:    cmd_in.kind = OP_CLEAR;
      OP_CHECKSUM: cmd_in.kind = OP_CHECKSUM;
      default:     cmd_in.kind = OP_NOP;
    endcase
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (cmd_pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    case ({push, cmd_pop_i})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/bfpc_back.sv */
`default_nettype none
`include "byte_fifo_with_peek_and_checksum_macros.svh"

module bfpc_back #(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cmd_valid_i,
  input  bfpc_pkg::cmd_t                cmd_i,
  output logic                          cmd_pop_o,
  output logic                          res_valid_o,
  output logic [bfpc_pkg::STATUS_W-1:0] status_o,
  output logic [bfpc_pkg::BYTE_W-1:0]   data_out_o,
  output logic [bfpc_pkg::SUM_W-1:0]    sum_o,
  output logic [bfpc_pkg::FILL_W-1:0]   fill_level_o
);
  import bfpc_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int EW = ((CW > LEN_W + 1) ? CW : LEN_W + 1) + 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WAIT,
    S_SUM
  } state_e;

  state_e              state_q, state_d;
  logic [AW-1:0]       rp_q, rp_d;
  logic [AW-1:0]       wp_q, wp_d;
  logic [CW-1:0]       count_q, count_d;
  logic [AW-1:0]       addr_q, addr_d;
  logic [LEN_W-1:0]    left_q, left_d;
  logic                pend_q, pend_d;
  logic [SUM_W-1:0]    acc_q, acc_d;
  logic                res_valid_q, res_valid_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic [BYTE_W-1:0]   dout_q, dout_d;
  logic [SUM_W-1:0]    sum_q, sum_d;
  logic [FILL_W-1:0]   fill_q, fill_d;

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rdata_q;
  logic                  mem_we;
  logic [AW-1:0]         mem_ra;

  logic [EW-1:0] count_e, pos_e, len_e, rp_e, clr_e, fill_e;
  logic [SUM_W-1:0] acc_next;

  function automatic logic [AW-1:0] wrap_idx(input logic [EW-1:0] v);
    logic [EW-1:0] w;
    w = (v >= EW'(DEPTH)) ? v - EW'(DEPTH) : v;
    return w[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] inc_idx(input logic [AW-1:0] a);
    return (a == AW'(DEPTH - 1)) ? '0 : a + 1'b1;
  endfunction

  assign count_e = EW'(count_q);
  assign pos_e   = EW'(cmd_i.pos);
  assign len_e   = EW'(cmd_i.len);
  assign rp_e    = EW'(rp_q);
  assign clr_e   = (len_e > count_e) ? count_e : len_e;

  always_comb begin
    state_d     = state_q;
    rp_d        = rp_q;
    wp_d        = wp_q;
    count_d     = count_q;
    addr_d      = addr_q;
    left_d      = left_q;
    pend_d      = pend_q;
    acc_d       = acc_q;
    res_valid_d = 1'b0;
    status_d    = ST_OK;
    dout_d      = '0;
    sum_d       = '0;
    mem_we      = 1'b0;
    mem_ra      = rp_q;
    cmd_pop_o   = 1'b0;
    acc_next    = acc_q + (pend_q ? SUM_W'(rdata_q[BYTE_W-1:0]) : '0);

    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          case (cmd_i.kind)
            OP_PUSH: begin
              res_valid_d = 1'b1;
              if (count_q == CW'(DEPTH)) begin
                status_d = ST_OVERFLOW;
              end else begin
                mem_we  = 1'b1;
                wp_d    = inc_idx(wp_q);
                count_d = count_q + 1'b1;
              end
            end
            OP_POP: begin
              if (count_q == '0) begin
                res_valid_d = 1'b1;
                status_d    = ST_UNDERFLOW;
              end else begin
                mem_ra  = rp_q;
                rp_d    = inc_idx(rp_q);
                count_d = count_q - 1'b1;
                state_d = S_WAIT;
              end
            end
            OP_PEEK: begin
              if (pos_e >= count_e) begin
                res_valid_d = 1'b1;
                status_d    = ST_SHORT;
              end else begin
                mem_ra  = wrap_idx(rp_e + pos_e);
                state_d = S_WAIT;
              end
            end
            OP_CLEAR: begin
              res_valid_d = 1'b1;
              rp_d        = wrap_idx(rp_e + clr_e);
              count_d     = count_q - clr_e[CW-1:0];
            end
            OP_CHECKSUM: begin
              if (pos_e + len_e > count_e) begin
                res_valid_d = 1'b1;
                status_d    = ST_SHORT;
              end else if (cmd_i.len == '0) begin
                res_valid_d = 1'b1;
              end else begin
                addr_d  = wrap_idx(rp_e + pos_e);
                left_d  = cmd_i.len;
                pend_d  = 1'b0;
                acc_d   = '0;
                state_d = S_SUM;
              end
            end
            default: begin
              res_valid_d = 1'b1;
            end
          endcase
        end
      end
      S_WAIT: begin
        res_valid_d = 1'b1;
        dout_d      = rdata_q[BYTE_W-1:0];
        state_d     = S_IDLE;
      end
      S_SUM: begin
        // issue one read a cycle, add each entry the cycle after its read
        acc_d = acc_next;
        if (left_q != '0) begin
          mem_ra = addr_q;
          addr_d = inc_idx(addr_q);
          left_d = left_q - 1'b1;
          pend_d = 1'b1;
        end else begin
          pend_d      = 1'b0;
          res_valid_d = 1'b1;
          sum_d       = acc_next;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    fill_e = EW'(count_d);
    fill_d = fill_e[FILL_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rp_q        <= '0;
      wp_q        <= '0;
      count_q     <= '0;
      addr_q      <= '0;
      left_q      <= '0;
      pend_q      <= 1'b0;
      acc_q       <= '0;
      res_valid_q <= 1'b0;
      status_q    <= ST_OK;
      dout_q      <= '0;
      sum_q       <= '0;
      fill_q      <= '0;
    end else begin
      state_q     <= state_d;
      rp_q        <= rp_d;
      wp_q        <= wp_d;
      count_q     <= count_d;
      addr_q      <= addr_d;
      left_q      <= left_d;
      pend_q      <= pend_d;
      acc_q       <= acc_d;
      res_valid_q <= res_valid_d;
      status_q    <= status_d;
      dout_q      <= dout_d;
      sum_q       <= sum_d;
      fill_q      <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wp_q] <= DATA_WIDTH'(cmd_i.data);
    end
    rdata_q <= mem[mem_ra];
  end

  assign res_valid_o  = res_valid_q;
  assign status_o     = status_q;
  assign data_out_o   = dout_q;
  assign sum_o        = sum_q;
  assign fill_level_o = fill_q;

  `BFPC_NEVER(a_count_bound, clk_i, rst_ni, count_q > CW'(DEPTH), "fill count above depth")
  `BFPC_ASSERT(a_push_count, clk_i, rst_ni, (state_q == S_IDLE) && cmd_valid_i && (cmd_i.kind == OP_PUSH) && (count_q != CW'(DEPTH)) |=> count_q == $past(count_q) + 1'b1, "accepted push did not raise the fill count")
  `BFPC_ASSERT(a_wait_result, clk_i, rst_ni, (state_q == S_WAIT) |=> res_valid_q, "read transaction ended without a result")
  `BFPC_NEVER(a_sum_stuck, clk_i, rst_ni, (state_q == S_SUM) && (left_q == '0) && !pend_q, "checksum walk with nothing left to add")

endmodule

`default_nettype wire

/* hw/rtl/byte_fifo_with_peek_and_checksum.sv */
// Results: push, clear, no-op, refused and zero-length checksum items give a registered
//   result strobe once the back end accepts them; pop and peek also pass through the
//   registered memory read and the wait state, other checksums through the summing walk
//   (1 read/cycle). Items may wait behind earlier ones in the two-entry command queue, and
//   the back end takes no new item until done with the last; the receiver cannot stall.
// Reset clears pointers, fill count and queue at once; the entry store is not cleared.
`default_nettype none

module byte_fifo_with_peek_and_checksum #(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [bfpc_pkg::OPCODE_W-1:0] opcode_i,
  input  logic [bfpc_pkg::BYTE_W-1:0]   data_in_i,
  input  logic [bfpc_pkg::POS_W-1:0]    position_i,
  input  logic [bfpc_pkg::LEN_W-1:0]    length_i,
  output logic                          result_valid_o,
  output logic [bfpc_pkg::STATUS_W-1:0] status_o,
  output logic [bfpc_pkg::BYTE_W-1:0]   data_out_o,
  output logic [bfpc_pkg::SUM_W-1:0]    sum_o,
  output logic [bfpc_pkg::FILL_W-1:0]   fill_level_o
);
  import bfpc_pkg::*;

  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;

  bfpc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .opcode_i    (opcode_i),
    .data_in_i   (data_in_i),
    .position_i  (position_i),
    .length_i    (length_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  bfpc_back #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (cmd_valid),
    .cmd_i        (cmd),
    .cmd_pop_o    (cmd_pop),
    .res_valid_o  (result_valid_o),
    .status_o     (status_o),
    .data_out_o   (data_out_o),
    .sum_o        (sum_o),
    .fill_level_o (fill_level_o)
  );

endmodule

`default_nettype wire
